// ===== rtl/core/uv_sphere_vertex_generator_core_assert.svh =====
// Assertion helpers shared by the core.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define UVS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uvs: same-cycle check failed");

// Next-cycle implication.
`define UVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uvs: next-cycle check failed");

`endif

// ===== rtl/core/uvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, types and helpers of the UV sphere vertex core.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int MAX_SLICES    = 1024;
   localparam int MAX_STACKS    = 1024;
   localparam int FRACTION_BITS = 16;

   localparam int RADIUS_W = 24;
   localparam int CNT_W    = 11;
   localparam int IDX_W    = 10;
   localparam int COORD_W  = 25;
   localparam int PHASE_W  = 32;
   localparam int DVD_W    = CNT_W + PHASE_W;
   localparam int DIV_CELLS    = DVD_W;
   localparam int CORDIC_CELLS = 30;
   localparam int CORD_W   = 34;
   localparam int TRIG_W   = 32;
   localparam int RS_W     = 27;
   localparam int PROD_W   = 59;
   localparam int RND_W    = PROD_W - 30;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1 << FRACTION_BITS);
   localparam logic [CNT_W-1:0]    SLICE_RESET  = CNT_W'(16);
   localparam logic [CNT_W-1:0]    STACK_RESET  = CNT_W'(8);
   localparam logic [CNT_W-1:0]    SLICE_MAX    = CNT_W'(MAX_SLICES);
   localparam logic [CNT_W-1:0]    STACK_MAX    = CNT_W'(MAX_STACKS);
   localparam logic [CORD_W-1:0]   CORDIC_GAIN  = CORD_W'(652032874);
   localparam logic signed [RND_W-1:0] COORD_LIMIT = RND_W'(16777215);

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_COUNT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_COUNT = CSR_IDX_W'(2);

   // angle op codes, bit 0 = next index, bit 1 = polar angle
   localparam logic [1:0] OP_A0 = 2'd0;
   localparam logic [1:0] OP_A1 = 2'd1;
   localparam logic [1:0] OP_B0 = 2'd2;
   localparam logic [1:0] OP_B1 = 2'd3;

   localparam logic [2:0] LAST_CORNER = 3'd5;

   typedef struct packed {
      logic             valid;
      logic [1:0]       op;
      logic [DVD_W-1:0] dvd;
      logic [PHASE_W-1:0] quo;
      logic [CNT_W-1:0] rem;
      logic [CNT_W-1:0] dvs;
   } div_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        op;
      logic              flip;
      logic [CORD_W-1:0] x;
      logic [CORD_W-1:0] y;
      logic [CORD_W-1:0] z;
   } cord_type;

   typedef struct packed {
      logic [TRIG_W-1:0]  sa0;
      logic [TRIG_W-1:0]  ca0;
      logic [TRIG_W-1:0]  sa1;
      logic [TRIG_W-1:0]  ca1;
      logic [RS_W-1:0]    rs0;
      logic [RS_W-1:0]    rs1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
   } rec_type;

   // arctangent of 2^-k in phase units (2^32 per turn)
   function automatic logic [PHASE_W-1:0] cordic_atan(input logic [4:0] k);
      logic [PHASE_W-1:0] v;
      case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = '0;
      endcase
      return v;
   endfunction

   // corner per output vertex: bit 0 = slice i+1, bit 1 = stack j+1
   function automatic logic [1:0] corner_of(input logic [2:0] k);
      logic [1:0] c;
      case (k)
         3'd0:    c = 2'd3;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd0;
         3'd3:    c = 2'd3;
         3'd4:    c = 2'd0;
         3'd5:    c = 2'd2;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // (p + 2^29) >> 30, floor shift
   function automatic logic signed [RND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(1 << 29);
      t = t >>> 30;
      return t[RND_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] r;
      if (v > COORD_LIMIT) r = COORD_LIMIT;
      else if (v < -COORD_LIMIT) r = -COORD_LIMIT;
      else r = v;
      return r[COORD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/uvs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs channel interfaces
// Cell request, vertex response and register write channels.
// ----------------------------------------------------------------------------
interface uvs_req_if import uvs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] slice_index;
   logic [IDX_W-1:0] stack_index;
   modport source (output valid, slice_index, stack_index, input ready);
   modport sink (input valid, slice_index, stack_index, output ready);
endinterface

interface uvs_rsp_if import uvs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] vertex_x;
   logic [COORD_W-1:0] vertex_y;
   logic [COORD_W-1:0] vertex_z;
   logic [2:0]         corner_number;
   logic               last_of_cell;
   modport source (output valid, vertex_x, vertex_y, vertex_z, corner_number,
                   last_of_cell, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_z, corner_number,
                 last_of_cell, output ready);
endinterface

interface uvs_csr_if import uvs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/uvs_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module uvs_div_cell import uvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  div_type cell_in,
   output div_type cell_out
);
   logic            valid_ff;
   div_type         data_ff;
   div_type         data_in;
   logic [CNT_W:0]  trial;
   logic            qbit;

   always_comb begin
      trial   = {cell_in.rem, cell_in.dvd[DVD_W-1]};
      qbit    = (trial >= {1'b0, cell_in.dvs});
      data_in = cell_in;
      data_in.rem = qbit ? CNT_W'(trial - {1'b0, cell_in.dvs}) : trial[CNT_W-1:0];
      data_in.quo = {cell_in.quo[PHASE_W-2:0], qbit};
      data_in.dvd = {cell_in.dvd[DVD_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end
endmodule

// ===== rtl/core/uvs_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One rotation-mode CORDIC micro-rotation; step number comes in as a tie-off.
// ----------------------------------------------------------------------------
module uvs_cordic_cell import uvs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [4:0] step,
   input  cord_type   cell_in,
   output cord_type   cell_out
);
   logic                     valid_ff;
   cord_type                 data_ff;
   cord_type                 data_in;
   logic signed [CORD_W-1:0] dx;
   logic signed [CORD_W-1:0] dy;
   logic signed [CORD_W-1:0] ang;

   always_comb begin
      dx  = $signed(cell_in.y) >>> step;
      dy  = $signed(cell_in.x) >>> step;
      ang = $signed({{(CORD_W-PHASE_W){1'b0}}, cordic_atan(step)});
      data_in = cell_in;
      if (!cell_in.z[CORD_W-1]) begin
         data_in.x = CORD_W'($signed(cell_in.x) - dx);
         data_in.y = CORD_W'($signed(cell_in.y) + dy);
         data_in.z = CORD_W'($signed(cell_in.z) - ang);
      end else begin
         data_in.x = CORD_W'($signed(cell_in.x) + dx);
         data_in.y = CORD_W'($signed(cell_in.y) - dy);
         data_in.z = CORD_W'($signed(cell_in.z) + ang);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end
endmodule

// ===== rtl/core/uvs_back_end.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_back_end
// Radius scaling, per-cell record assembly, record queue and vertex emitter.
// ----------------------------------------------------------------------------
module uvs_back_end import uvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [RADIUS_W-1:0] radius,
   input  cord_type            cord_in,
   uvs_rsp_if.source           rsp,
   output logic                pop
);
   // trig finish + radius products
   logic                     p1_v_ff;
   logic [1:0]               p1_op_ff;
   logic [TRIG_W-1:0]        p1_s_ff, p1_c_ff;
   logic signed [PROD_W-1:0] p1_ps_ff, p1_pc_ff;
   logic [TRIG_W-1:0]        s_in, c_in;
   logic signed [PROD_W-1:0] ps_in, pc_in;

   always_comb begin
      s_in = cord_in.flip ? TRIG_W'(-$signed(cord_in.y)) : cord_in.y[TRIG_W-1:0];
      c_in = cord_in.flip ? TRIG_W'(-$signed(cord_in.x)) : cord_in.x[TRIG_W-1:0];
      ps_in = $signed({1'b0, radius}) * $signed(s_in);
      pc_in = $signed({1'b0, radius}) * $signed(c_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cord_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_op_ff <= cord_in.op;
      p1_s_ff  <= s_in;
      p1_c_ff  <= c_in;
      p1_ps_ff <= ps_in;
      p1_pc_ff <= pc_in;
   end

   // record assembly
   rec_type                 rec_ff, rec_in, push_rec;
   logic                    push;
   logic signed [RND_W-1:0] rs_r, y_r;

   always_comb begin
      rs_r = round_q30(p1_ps_ff);
      y_r  = round_q30(p1_pc_ff);
      rec_in = rec_ff;
      if (p1_v_ff) begin
         case (p1_op_ff)
            OP_A0: begin
               rec_in.sa0 = p1_s_ff;
               rec_in.ca0 = p1_c_ff;
            end
            OP_A1: begin
               rec_in.sa1 = p1_s_ff;
               rec_in.ca1 = p1_c_ff;
            end
            OP_B0: begin
               rec_in.rs0 = rs_r[RS_W-1:0];
               rec_in.y0  = clamp_coord(y_r);
            end
            OP_B1: begin
               rec_in.rs1 = rs_r[RS_W-1:0];
               rec_in.y1  = clamp_coord(y_r);
            end
            default: rec_in = rec_ff;
         endcase
      end
      push_rec = rec_in;
      push     = p1_v_ff && (p1_op_ff == OP_B1);
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // record queue; upstream credit keeps it from overflowing
   rec_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;

   // emitter
   logic                     s1_v_ff, out_v_ff;
   logic [2:0]               k_ff, s1_k_ff, out_k_ff;
   logic signed [PROD_W-1:0] s1_px_ff, s1_pz_ff;
   logic [COORD_W-1:0]       s1_y_ff;
   logic [COORD_W-1:0]       out_x_ff, out_y_ff, out_z_ff;
   logic                     s2_adv, s1_load;
   rec_type                  head;
   logic [1:0]               sel;
   logic [TRIG_W-1:0]        sa, ca;
   logic [RS_W-1:0]          rs;
   logic [COORD_W-1:0]       yv;

   always_comb begin
      head    = fifo_ff[rd_ptr_ff];
      sel     = corner_of(k_ff);
      sa      = sel[0] ? head.sa1 : head.sa0;
      ca      = sel[0] ? head.ca1 : head.ca0;
      rs      = sel[1] ? head.rs1 : head.rs0;
      yv      = sel[1] ? head.y1  : head.y0;
      s2_adv  = !out_v_ff || rsp.ready;
      s1_load = (cnt_ff != '0) && (!s1_v_ff || s2_adv);
      pop     = s1_load && (k_ff == LAST_CORNER);
      cnt_in  = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
         s1_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (s1_load) begin
            k_ff <= (k_ff == LAST_CORNER) ? 3'd0 : k_ff + 3'd1;
         end
         if (s1_load) begin
            s1_v_ff <= 1'b1;
         end else if (s2_adv) begin
            s1_v_ff <= 1'b0;
         end
         if (s2_adv) begin
            out_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_rec;
      end
      if (s1_load) begin
         s1_k_ff  <= k_ff;
         s1_y_ff  <= yv;
         s1_px_ff <= $signed(rs) * $signed(sa);
         s1_pz_ff <= $signed(rs) * $signed(ca);
      end
      if (s2_adv && s1_v_ff) begin
         out_k_ff <= s1_k_ff;
         out_y_ff <= s1_y_ff;
         out_x_ff <= clamp_coord(round_q30(s1_px_ff));
         out_z_ff <= clamp_coord(round_q30(s1_pz_ff));
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.vertex_x      = out_x_ff;
   assign rsp.vertex_y      = out_y_ff;
   assign rsp.vertex_z      = out_z_ff;
   assign rsp.corner_number = out_k_ff;
   assign rsp.last_of_cell  = (out_k_ff == LAST_CORNER);
endmodule

// ===== rtl/core/uv_sphere_vertex_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// Latitude-longitude sphere tessellator: one cell in, six vertices out.
// ----------------------------------------------------------------------------
// Each accepted cell word (slice i, stack j) yields six vertex words, two
// triangles, corners in the order (i+1,j+1) (i+1,j) (i,j) (i+1,j+1) (i,j)
// (i,j+1), the sixth flagged last_of_cell. Coordinates are signed Q8.16,
// saturated to +-16777215. The sustained cell rate is set by the vertex
// emitter, which sends one vertex per cycle while the output is not
// stalled; the front end sends four angle words per cell into the cell
// chains and takes no new cell meanwhile. From cell accept to the first
// vertex word, 43 divider cells turn index/count into a 32-bit phase, 30
// CORDIC cells give sine and cosine, then radius scaling and the emitter.
// Up to 16 cells may be in flight. Register writes (radius, slice and stack
// count) are taken any cycle but must only happen while idle.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_core_assert.svh"

module uv_sphere_vertex_generator_core import uvs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch,
   uvs_csr_if.sink   csr_ch
);
   // ---- configuration registers ----
   logic [RADIUS_W-1:0] radius_ff;
   logic [CNT_W-1:0]    slice_ff, stack_ff;
   logic [CNT_W-1:0]    wr_cnt;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      // only the low 11 data bits count: zero acts as one, beyond the maximum acts as the maximum
      wr_cnt = csr_ch.data[CNT_W-1:0];
      if (wr_cnt == '0) begin
         wr_cnt = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         slice_ff  <= SLICE_RESET;
         stack_ff  <= STACK_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RADIUS:      radius_ff <= csr_ch.data[RADIUS_W-1:0];
            CSR_SLICE_COUNT: slice_ff  <= (wr_cnt > SLICE_MAX) ? SLICE_MAX : wr_cnt;
            CSR_STACK_COUNT: stack_ff  <= (wr_cnt > STACK_MAX) ? STACK_MAX : wr_cnt;
            default: ;
         endcase
      end
   end

   // ---- cell intake and angle word issue ----
   logic             busy_ff;
   logic [1:0]       op_ff;
   logic [IDX_W-1:0] i_ff, j_ff;
   logic [FIFO_AW:0] inflight_ff;
   logic             req_acc, emit_pop;

   assign req_ch.ready = !busy_ff && (inflight_ff < (FIFO_AW+1)'(FIFO_DEPTH));
   assign req_acc      = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         op_ff       <= OP_A0;
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + (FIFO_AW+1)'(req_acc) - (FIFO_AW+1)'(emit_pop);
         if (req_acc) begin
            busy_ff <= 1'b1;
            op_ff   <= OP_A0;
         end else if (busy_ff) begin
            op_ff <= op_ff + 2'd1;
            if (op_ff == OP_B1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         i_ff <= req_ch.slice_index;
         j_ff <= req_ch.stack_index;
      end
   end

   function automatic logic [IDX_W-1:0] j_or_i(input logic [1:0] op);
      return op[1] ? j_ff : i_ff;
   endfunction

   // phase = (idx * 2^32 + n/2) / n for azimuth, (idx * 2^31 + m/2) / m polar
   div_type          div_pipe [DIV_CELLS+1];
   logic [CNT_W-1:0] idx, dvs;

   always_comb begin
      idx = op_ff[0] ? CNT_W'(j_or_i(op_ff)) + CNT_W'(1) : CNT_W'(j_or_i(op_ff));
      dvs = op_ff[1] ? stack_ff : slice_ff;
      div_pipe[0].valid = busy_ff;
      div_pipe[0].op    = op_ff;
      div_pipe[0].rem   = '0;
      div_pipe[0].quo   = '0;
      div_pipe[0].dvs   = dvs;
      if (op_ff[1]) begin
         div_pipe[0].dvd = {1'b0, idx, {(PHASE_W-1){1'b0}}} + DVD_W'(dvs[CNT_W-1:1]);
      end else begin
         div_pipe[0].dvd = {idx, {PHASE_W{1'b0}}} + DVD_W'(dvs[CNT_W-1:1]);
      end
   end

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      uvs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (div_pipe[g]),
         .cell_out (div_pipe[g+1])
      );
   end

   // ---- quadrant fold, then CORDIC chain ----
   cord_type           cord_pipe [CORDIC_CELLS+1];
   logic [PHASE_W-1:0] ph;
   logic               flip;

   always_comb begin
      ph   = div_pipe[DIV_CELLS].quo;
      // second or third quadrant: rotate by half a turn, negate results
      flip = ph[PHASE_W-1] ^ ph[PHASE_W-2];
      if (flip) begin
         ph[PHASE_W-1] = ~ph[PHASE_W-1];
      end
      cord_pipe[0].valid = div_pipe[DIV_CELLS].valid;
      cord_pipe[0].op    = div_pipe[DIV_CELLS].op;
      cord_pipe[0].flip  = flip;
      cord_pipe[0].x     = CORDIC_GAIN;
      cord_pipe[0].y     = '0;
      cord_pipe[0].z     = {{(CORD_W-PHASE_W){ph[PHASE_W-1]}}, ph};
   end

   for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
      uvs_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (5'(g)),
         .cell_in  (cord_pipe[g]),
         .cell_out (cord_pipe[g+1])
      );
   end

   // ---- scaling, record queue, vertex output ----
   uvs_back_end u_back (
      .clock   (clock),
      .reset   (reset),
      .radius  (radius_ff),
      .cord_in (cord_pipe[CORDIC_CELLS]),
      .rsp     (rsp_ch),
      .pop     (emit_pop)
   );

   // ---- checks ----
   `UVS_ASSERT_IMPL(a_credit_bound, clock, reset, 1'b1, inflight_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
   `UVS_ASSERT_IMPL(a_pop_has_cell, clock, reset, emit_pop, inflight_ff != '0)
   `UVS_ASSERT_NEXT(a_accept_issues, clock, reset, req_acc, busy_ff && op_ff == OP_A0)
   `UVS_ASSERT_IMPL(a_last_flag, clock, reset, rsp_ch.valid, rsp_ch.last_of_cell == (rsp_ch.corner_number == LAST_CORNER))
endmodule
